/* src/cordic_sine_cosine_degrees_macros.svh */
// Assertion macros for the degree-input CORDIC sine and cosine block
`ifndef CORDIC_SINE_COSINE_DEGREES_MACROS_SVH
`define CORDIC_SINE_COSINE_DEGREES_MACROS_SVH

// Consequence must hold at the delay given by n after the antecedent
`define CSCD_ASSERT_AFTER(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##n (cons)) else $error(msg);

// Consequence must hold in the same cycle as the antecedent
`define CSCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* src/cscd_pkg.sv */
// Shared constants for the degree-input CORDIC sine and cosine block
package cscd_pkg;

    localparam int ANGLE_W   = 21;
    localparam int OUT_W     = 16;
    localparam int TABLE_LEN = 20;

    // arctan(2^-j) in degrees, scaled by 10000
    localparam longint ATAN_E4 [TABLE_LEN] = '{
        450000, 265651, 140362, 71250, 35763,
        17899, 8952, 4476, 2238, 1119,
        560, 280, 140, 70, 35,
        17, 9, 4, 2, 1
    };

    // Start value of the x component: the gain correction 0.6073, scaled by 10000
    localparam longint START_E4 = 6073;

endpackage

/* src/cordic_sine_cosine_degrees.sv */
// Pipelined rotation-mode CORDIC: sine and cosine of an angle in degrees
//
// Usage
//   Input: drive angle (degrees, signed, ANGLE_FRAC_BITS fraction bits) and
//   last_in, and raise start for one cycle per beat. A beat is taken at every
//   rising edge where start is high and busy is low; busy stays low, so a new
//   beat may be offered in every cycle.
//   Output: done is high for exactly one cycle per beat, with sine, cosine
//   (signed, OUT_FRAC_BITS fraction bits, saturated to 16 bits) and last_out
//   valid in that cycle. The receiver cannot hold results off.
//   Pipeline from start to done: one fold stage, one register stage per
//   micro-rotation (min(ITERATIONS, 20) of them), one negate/saturate stage.
//   Throughput: one beat per cycle; the depth of the rotation pipeline sets
//   the latency only.
//   Angles in (90,180] or [-180,-90) are moved by 180 degrees and both
//   results negated; angles beyond +/-180 give sine 0 and cosine about 1.
//   Reset clears every valid bit at once; beats in flight are dropped and no
//   done follows for them.
module cordic_sine_cosine_degrees #(
    parameter int ITERATIONS      = 16,
    parameter int ANGLE_FRAC_BITS = 12,
    parameter int OUT_FRAC_BITS   = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cscd_pkg::ANGLE_W-1:0] angle,
    input  logic                                last_in,
    output logic                                done,
    output logic signed [cscd_pkg::OUT_W-1:0]   sine,
    output logic signed [cscd_pkg::OUT_W-1:0]   cosine,
    output logic                                last_out
);

    import cscd_pkg::*;

`include "cordic_sine_cosine_degrees_macros.svh"

    // Number of micro-rotations actually built
    localparam int N_ITER = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    // Vector width: headroom above 1.0 for the gain and truncation slop
    localparam int XW = OUT_FRAC_BITS + 3;
    // Residual angle width: |z| stays below 190 degrees
    localparam int ZW = ANGLE_FRAC_BITS + 9;
    // Width for range checks on the raw angle
    localparam int CW = (ZW > ANGLE_W + 1) ? ZW : ANGLE_W + 1;
    // Width for negation and saturation
    localparam int NW = XW + 1;
    localparam int SW = (NW > OUT_W + 1) ? NW : OUT_W + 1;
    localparam int LAT = N_ITER + 2;

    localparam logic signed [CW-1:0] DEG90  = CW'(longint'(90) <<< ANGLE_FRAC_BITS);
    localparam logic signed [CW-1:0] DEG180 = CW'(longint'(180) <<< ANGLE_FRAC_BITS);
    localparam logic signed [XW-1:0] X_START =
        XW'(((START_E4 <<< OUT_FRAC_BITS) + 5000) / 10000);
    localparam logic signed [SW-1:0] SAT_HI = SW'(32'sd32767);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-32'sd32768);

    // Pipeline registers; index 0 is the fold stage, index j+1 follows rotation j
    logic                 vld_reg  [0:N_ITER];
    logic                 neg_reg  [0:N_ITER];
    logic                 last_reg [0:N_ITER];
    logic signed [XW-1:0] x_reg    [0:N_ITER];
    logic signed [XW-1:0] y_reg    [0:N_ITER];
    logic signed [ZW-1:0] z_reg    [0:N_ITER];

    // Output stage
    logic                    done_reg;
    logic                    last_out_reg;
    logic signed [OUT_W-1:0] sine_reg;
    logic signed [OUT_W-1:0] cosine_reg;
    logic signed [OUT_W-1:0] sine_next;
    logic signed [OUT_W-1:0] cosine_next;

    // Fold stage signals
    logic signed [CW-1:0] a_ext;
    logic signed [CW-1:0] z_fold;
    logic                 neg_fold;
    logic                 oor;
    logic                 accept;

    // The pipeline never stalls, so every start is a beat
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Fold the angle into [-90,90]; zero anything beyond +/-180
    always_comb
    begin
        a_ext    = CW'(angle);
        z_fold   = a_ext;
        neg_fold = 1'b0;
        oor      = 1'b0;
        if (a_ext <= DEG90 && a_ext >= -DEG90)
        begin
            z_fold = a_ext;
        end
        else if (a_ext > DEG90 && a_ext <= DEG180)
        begin
            z_fold   = a_ext - DEG180;
            neg_fold = 1'b1;
        end
        else if (a_ext < -DEG90 && a_ext >= -DEG180)
        begin
            z_fold   = a_ext + DEG180;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold = '0;
            oor    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
        end
    end

    // Payload needs no reset: the valid bit qualifies it
    always_ff @(posedge clk)
    begin
        neg_reg[0]  <= neg_fold;
        last_reg[0] <= last_in;
        x_reg[0]    <= X_START;
        y_reg[0]    <= '0;
        z_reg[0]    <= ZW'(z_fold);
    end

    // One register stage per micro-rotation
    for (genvar j = 0; j < N_ITER; j++)
    begin : g_rot
        localparam logic signed [ZW-1:0] STEP =
            ZW'(((ATAN_E4[j] <<< ANGLE_FRAC_BITS) + 5000) / 10000);

        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            xs = x_reg[j] >>> j;
            ys = y_reg[j] >>> j;
            if (!z_reg[j][ZW-1])
            begin
                x_next = x_reg[j] - ys;
                y_next = y_reg[j] + xs;
                z_next = z_reg[j] - STEP;
            end
            else
            begin
                x_next = x_reg[j] + ys;
                y_next = y_reg[j] - xs;
                z_next = z_reg[j] + STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[j+1]  <= neg_reg[j];
            last_reg[j+1] <= last_reg[j];
            x_reg[j+1]    <= x_next;
            y_reg[j+1]    <= y_next;
            z_reg[j+1]    <= z_next;
        end
    end

    // Undo the fold by negating, then clamp to the 16-bit range
    always_comb
    begin
        logic signed [SW-1:0] xn;
        logic signed [SW-1:0] yn;
        xn = SW'(x_reg[N_ITER]);
        yn = SW'(y_reg[N_ITER]);
        if (neg_reg[N_ITER])
        begin
            xn = -xn;
            yn = -yn;
        end
        if (yn > SAT_HI)
        begin
            sine_next = OUT_W'(SAT_HI);
        end
        else if (yn < SAT_LO)
        begin
            sine_next = OUT_W'(SAT_LO);
        end
        else
        begin
            sine_next = OUT_W'(yn);
        end
        if (xn > SAT_HI)
        begin
            cosine_next = OUT_W'(SAT_HI);
        end
        else if (xn < SAT_LO)
        begin
            cosine_next = OUT_W'(SAT_LO);
        end
        else
        begin
            cosine_next = OUT_W'(xn);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[N_ITER];
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg     <= sine_next;
        cosine_reg   <= cosine_next;
        last_out_reg <= last_reg[N_ITER];
    end

    assign done     = done_reg;
    assign sine     = sine_reg;
    assign cosine   = cosine_reg;
    assign last_out = last_out_reg;

    // Every beat taken comes out of the pipeline as a done
    `CSCD_ASSERT_AFTER(a_beat_out, accept, LAT, done, "beat lost in pipeline")
    // No result without a beat taken earlier
    `CSCD_ASSERT_AFTER(a_no_spurious, !accept, LAT, !done, "result without a beat")
    // An angle beyond +/-180 enters the rotations as zero, unfolded
    `CSCD_ASSERT_AFTER(a_oor_zero, accept && oor, 1,
        vld_reg[0] && z_reg[0] == '0 && !neg_reg[0],
        "out-of-range angle not replaced by zero")
    // The block always takes a beat
    `CSCD_ASSERT_NOW(a_never_busy, start, !busy, "start refused")

endmodule
